[rtl/core/awsh_pkg.sv]
// awsh_pkg: shared constants, codes and CORDIC angle constants for the waveshaper core
// used by awsh_cordic_cell and audio_waveshaper_core; no dependencies
`default_nettype none
package awsh_pkg;

  typedef enum logic [1:0] {
    MODE_TANH     = 2'd0,
    MODE_ATAN     = 2'd1,
    MODE_RATIONAL = 2'd2,
    MODE_THRESH   = 2'd3
  } shape_mode_t;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE_MODE   = 2'd0,
    CFG_DRIVE_AMOUNT = 2'd1,
    CFG_INPUT_GAIN   = 2'd2
  } cfg_idx_t;

  localparam int A_W   = 39;
  localparam int XY_W  = 45;
  localparam int Z_W   = 33;
  localparam int PD_W  = 17;
  localparam int PD_QW = 34;
  localparam int PD_PW = A_W + 2;
  localparam int FD_W  = 44;
  localparam int FD_QW = 32;
  localparam int R_W   = 33;
  localparam int FD_PW = R_W + 2;
  localparam int K_MAX = 23;

  localparam logic [29:0] LN2_Q30         = 30'd744261118;
  localparam logic [17:0] PI_Q16          = 18'd205887;
  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
  localparam logic [26:0] TENTH_Q30       = 27'd107374182;
  localparam logic [24:0] THRESH_Q30      = 25'd32212254;
  localparam logic [16:0] DRIVE_ONE       = 17'h10000;
  localparam logic [28:0] Q28_ONE         = 29'h1000_0000;
  localparam logic [R_W-1:0] R_ONE        = 33'h0_8000_0000;
  localparam logic [R_W-1:0] R_TWO        = 33'h1_0000_0000;

  // hyperbolic shift sequence with repeats at 4 and 13
  function automatic int hyp_shift(input int n);
    int s;
    if (n <= 3) s = n + 1;
    else if (n <= 13) s = n;
    else s = n - 1;
    return s;
  endfunction

  function automatic int circ_angle(input int i);
    int v;
    case (i)
      0: v = 843314857;   1: v = 497837829;   2: v = 263043837;   3: v = 133525159;
      4: v = 67021687;    5: v = 33543516;    6: v = 16775851;    7: v = 8388437;
      8: v = 4194283;     9: v = 2097149;     10: v = 1048576;    11: v = 524288;
      12: v = 262144;     13: v = 131072;     14: v = 65536;      15: v = 32768;
      16: v = 16384;      17: v = 8192;       18: v = 4096;       19: v = 2048;
      20: v = 1024;       21: v = 512;        22: v = 256;        23: v = 128;
      24: v = 64;         25: v = 32;         26: v = 16;         27: v = 8;
      28: v = 4;          29: v = 2;          30: v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic int hyp_angle(input int i);
    int v;
    case (i)
      1: v = 589812981;   2: v = 274247418;   3: v = 134923406;   4: v = 67196451;
      5: v = 33565361;    6: v = 16778582;    7: v = 8388779;     8: v = 4194325;
      9: v = 2097155;     10: v = 1048576;    11: v = 524288;     12: v = 262144;
      13: v = 131072;     14: v = 65536;      15: v = 32768;      16: v = 16384;
      17: v = 8192;       18: v = 4096;       19: v = 2048;       20: v = 1024;
      21: v = 512;        22: v = 256;        23: v = 128;        24: v = 64;
      25: v = 32;         26: v = 16;         27: v = 8;          28: v = 4;
      29: v = 2;          30: v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/audio_waveshaper_core.sv]
// audio_waveshaper_core: one transfer per cycle sustained while the skid entry stays empty, set by
// the fully pipelined cell chains (34-step divider, CORDIC_STAGES rotation cells, 31-step divider),
// all advancing together
// a two-entry output (register plus skid) keeps input open while one result waits
// synchronous active-low reset clears valids and loads register defaults; no clearing pass
// depends on awsh_pkg, awsh_div_cell, awsh_cordic_cell
`default_nettype none
module audio_waveshaper_core #(
  parameter int SAMPLE_BITS   = 24,
  parameter int CORDIC_STAGES = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_out,
  input  logic                                cfg_we,
  input  logic [awsh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [24:0]                         cfg_wdata
);

  localparam int S     = SAMPLE_BITS;
  localparam int C     = CORDIC_STAGES;
  localparam int PRW   = S + 25;
  localparam int AW    = awsh_pkg::A_W;
  localparam int XYW   = awsh_pkg::XY_W;
  localparam int ZW    = awsh_pkg::Z_W;
  localparam int PDW   = awsh_pkg::PD_W;
  localparam int PDQ   = awsh_pkg::PD_QW;
  localparam int PDP   = awsh_pkg::PD_PW;
  localparam int FDW   = awsh_pkg::FD_W;
  localparam int FDQ   = awsh_pkg::FD_QW;
  localparam int FDP   = awsh_pkg::FD_PW;
  localparam int RW    = awsh_pkg::R_W;
  localparam int FDN   = FDQ - 1;
  localparam logic [S:0] POS_CAP = {2'b00, {(S-1){1'b1}}};
  localparam logic [S:0] NEG_CAP = {2'b01, {(S-1){1'b0}}};

  // configuration
  awsh_pkg::shape_mode_t mode_r;
  logic [15:0]           drive_r;
  logic [24:0]           gain_r;
  logic [16:0]           drv_comp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= awsh_pkg::MODE_ATAN;
      drive_r <= 16'd16384;
      gain_r  <= 25'd65536;
    end else if (cfg_we) begin
      unique case (awsh_pkg::cfg_idx_t'(cfg_index))
        awsh_pkg::CFG_SHAPE_MODE:   mode_r  <= awsh_pkg::shape_mode_t'(cfg_wdata[1:0]);
        awsh_pkg::CFG_DRIVE_AMOUNT: drive_r <= cfg_wdata[15:0];
        awsh_pkg::CFG_INPUT_GAIN:   gain_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign drv_comp = awsh_pkg::DRIVE_ONE - {1'b0, drive_r};

  logic en;
  logic skid_v_r, out_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage 1: magnitude and sign
  logic           st1_v_r, st1_neg_r;
  logic [S-1:0]   st1_mag_r, raw;
  assign raw = in_sample_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
    end else if (en) begin
      st1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_neg_r <= raw[S-1];
      st1_mag_r <= raw[S-1] ? (~raw + 1'b1) : raw;
    end
  end

  // stage 2: input gain
  logic           st2_v_r, st2_neg_r;
  logic [AW-1:0]  st2_a_r;
  logic [PRW-1:0] gprod;
  assign gprod = PRW'(st1_mag_r) * PRW'(gain_r);

  // stage 3: tanh range check
  logic           st3_v_r, st3_neg_r, st3_ovf_r;
  logic [AW-1:0]  st3_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_v_r <= 1'b0;
      st3_v_r <= 1'b0;
    end else if (en) begin
      st2_v_r <= st1_v_r;
      st3_v_r <= st2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_neg_r <= st1_neg_r;
      st2_a_r   <= gprod[S+23:S-15];
      st3_neg_r <= st2_neg_r;
      st3_a_r   <= st2_a_r;
      st3_ovf_r <= st2_a_r >= {4'b0, drv_comp, 18'b0};
    end
  end

  // tanh argument divider: v = a * 2^16 / (1 - d)
  logic           pd_vld [0:PDQ];
  logic [PDW-1:0] pd_rem [0:PDQ];
  logic [PDW-1:0] pd_div [0:PDQ];
  logic [PDQ-1:0] pd_quo [0:PDQ];
  logic [PDP-1:0] pd_pay [0:PDQ];
  logic           pd_bit [0:PDQ-1];

  assign pd_vld[0] = st3_v_r;
  assign pd_rem[0] = st3_a_r[34:18];
  assign pd_div[0] = drv_comp;
  assign pd_quo[0] = '0;
  assign pd_pay[0] = {st3_neg_r, st3_ovf_r, st3_a_r};

  for (genvar i = 0; i < PDQ; i++) begin : g_pd
    if (i <= 17) begin : g_bit
      assign pd_bit[i] = pd_pay[i][17-i];
    end else begin : g_zero
      assign pd_bit[i] = 1'b0;
    end
    awsh_div_cell #(.W(PDW), .QW(PDQ), .PW(PDP)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (pd_vld[i]),
      .in_rem  (pd_rem[i]),
      .in_div  (pd_div[i]),
      .in_quo  (pd_quo[i]),
      .in_bit  (pd_bit[i]),
      .in_pay  (pd_pay[i]),
      .out_vld (pd_vld[i+1]),
      .out_rem (pd_rem[i+1]),
      .out_div (pd_div[i+1]),
      .out_quo (pd_quo[i+1]),
      .out_pay (pd_pay[i+1])
    );
  end

  // stage 4: split v into k * ln2 + rem
  logic           st4_v_r, st4_neg_r, st4_ovf_r;
  logic [AW-1:0]  st4_a_r;
  logic [4:0]     st4_k_r, kq;
  logic [29:0]    st4_rem_r;
  logic [33:0]    remq;

  always_comb begin
    kq = '0;
    for (int j = 1; j <= awsh_pkg::K_MAX; j++) begin
      if (pd_quo[PDQ] >= 34'(j) * awsh_pkg::LN2_Q30) kq = 5'(j);
    end
    remq = pd_quo[PDQ] - 34'(kq) * awsh_pkg::LN2_Q30;
  end

  // stage 5: CORDIC start vectors
  logic                 cr_vld [0:C];
  logic signed [XYW-1:0] cr_x  [0:C];
  logic signed [XYW-1:0] cr_y  [0:C];
  logic signed [ZW-1:0]  cr_z  [0:C];
  logic [PDP-1:0]        cr_pay [0:C];
  logic                  st5_v_r;
  logic signed [XYW-1:0] st5_x_r, st5_y_r;
  logic signed [ZW-1:0]  st5_z_r;
  logic [PDP-1:0]        st5_pay_r;
  logic [28:0]           tail;
  logic [56:0]           ya_prod;
  logic                  hyp;

  assign hyp     = mode_r == awsh_pkg::MODE_TANH;
  assign tail    = awsh_pkg::Q28_ONE >> {st4_k_r, 1'b0};
  assign ya_prod = 57'(st4_a_r) * 57'(awsh_pkg::PI_Q16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st4_v_r <= 1'b0;
      st5_v_r <= 1'b0;
    end else if (en) begin
      st4_v_r <= pd_vld[PDQ];
      st5_v_r <= st4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st4_neg_r <= pd_pay[PDQ][AW+1];
      st4_ovf_r <= pd_pay[PDQ][AW];
      st4_a_r   <= pd_pay[PDQ][AW-1:0];
      st4_k_r   <= kq;
      st4_rem_r <= remq[29:0];
      st5_pay_r <= {st4_neg_r, st4_ovf_r, st4_a_r};
      if (hyp) begin
        st5_x_r <= XYW'({1'b0, awsh_pkg::Q28_ONE} + {1'b0, tail});
        st5_y_r <= XYW'({1'b0, awsh_pkg::Q28_ONE} - {1'b0, tail});
        st5_z_r <= ZW'(st4_rem_r);
      end else begin
        st5_x_r <= XYW'({drv_comp, 15'b0});
        st5_y_r <= XYW'(ya_prod[56:16]);
        st5_z_r <= '0;
      end
    end
  end

  assign cr_vld[0] = st5_v_r;
  assign cr_x[0]   = st5_x_r;
  assign cr_y[0]   = st5_y_r;
  assign cr_z[0]   = st5_z_r;
  assign cr_pay[0] = st5_pay_r;

  for (genvar n = 0; n < C; n++) begin : g_cr
    awsh_cordic_cell #(.STAGE(n), .XW(XYW), .ZW(ZW), .PW(PDP)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .hyp     (hyp),
      .in_vld  (cr_vld[n]),
      .in_x    (cr_x[n]),
      .in_y    (cr_y[n]),
      .in_z    (cr_z[n]),
      .in_pay  (cr_pay[n]),
      .out_vld (cr_vld[n+1]),
      .out_x   (cr_x[n+1]),
      .out_y   (cr_y[n+1]),
      .out_z   (cr_z[n+1]),
      .out_pay (cr_pay[n+1])
    );
  end

  // stage 6: angle scaling and rational denominator
  logic                  st6_v_r, st6_neg_r, st6_ovf_r, st6_zpos_r;
  logic [AW-1:0]         st6_a_r;
  logic [31:0]           st6_atan_r;
  logic [39:0]           st6_den_r;
  logic signed [XYW-1:0] st6_x_r, st6_y_r;
  logic [63:0]           at_prod;
  logic [54:0]           dn_prod;

  assign at_prod = 64'(cr_z[C][31:0]) * 64'(awsh_pkg::TWO_OVER_PI_Q32);
  assign dn_prod = 55'(cr_pay[C][AW-1:0]) * 55'(drive_r);

  // stage 7: curve select
  logic                  st7_v_r, st7_neg_r, st7_dirf_r;
  logic [RW-1:0]         st7_rdir_r;
  logic [FDW-1:0]        st7_n_r, st7_dv_r;
  logic                  dirf;
  logic [RW-1:0]         rdir;
  logic [FDW-1:0]        num, dv;

  always_comb begin
    dirf = 1'b1;
    rdir = '0;
    num  = '0;
    dv   = '0;
    if (st6_a_r != '0) begin
      unique case (mode_r)
        awsh_pkg::MODE_TANH: begin
          if (st6_ovf_r) begin
            rdir = awsh_pkg::R_ONE;
          end else if (st6_y_r <= 0) begin
            rdir = '0;
          end else if (st6_x_r <= 0) begin
            rdir = awsh_pkg::R_TWO;
          end else begin
            dirf = 1'b0;
            num  = st6_y_r[FDW-1:0];
            dv   = st6_x_r[FDW-1:0];
          end
        end
        awsh_pkg::MODE_ATAN: begin
          rdir = st6_zpos_r ? {1'b0, st6_atan_r} : '0;
        end
        awsh_pkg::MODE_RATIONAL: begin
          dirf = 1'b0;
          num  = FDW'(st6_a_r);
          dv   = FDW'(st6_den_r);
        end
        awsh_pkg::MODE_THRESH: begin
          if (st6_a_r > AW'(awsh_pkg::THRESH_Q30)) begin
            dirf = 1'b0;
            num  = FDW'(awsh_pkg::TENTH_Q30);
            dv   = FDW'({drv_comp, 14'b0});
          end else begin
            rdir = RW'({st6_a_r, 1'b0});
          end
        end
        default: ;
      endcase
    end
  end

  // stage 8: ratio cap and leading quotient bit
  logic                  st8_v_r, st8_neg_r, st8_dirf_r, st8_q0_r;
  logic [RW-1:0]         st8_rdir_r;
  logic [FDW-1:0]        st8_rem_r, st8_div_r;
  logic                  dcap, q0;

  assign dcap = (st7_dv_r == '0) || ({1'b0, st7_n_r} >= {st7_dv_r, 1'b0});
  assign q0   = st7_n_r >= st7_dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st6_v_r <= 1'b0;
      st7_v_r <= 1'b0;
      st8_v_r <= 1'b0;
    end else if (en) begin
      st6_v_r <= cr_vld[C];
      st7_v_r <= st6_v_r;
      st8_v_r <= st7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st6_neg_r  <= cr_pay[C][AW+1];
      st6_ovf_r  <= cr_pay[C][AW];
      st6_a_r    <= cr_pay[C][AW-1:0];
      st6_zpos_r <= !cr_z[C][ZW-1] && (cr_z[C] != '0);
      st6_atan_r <= at_prod[62:31];
      st6_den_r  <= 40'h40000000 + 40'(dn_prod[54:16]);
      st6_x_r    <= cr_x[C];
      st6_y_r    <= cr_y[C];
      st7_neg_r  <= st6_neg_r;
      st7_dirf_r <= dirf;
      st7_rdir_r <= rdir;
      st7_n_r    <= num;
      st7_dv_r   <= dv;
      st8_neg_r  <= st7_neg_r;
      st8_dirf_r <= st7_dirf_r || dcap;
      st8_rdir_r <= st7_dirf_r ? st7_rdir_r : awsh_pkg::R_TWO;
      st8_q0_r   <= q0;
      st8_rem_r  <= q0 ? st7_n_r - st7_dv_r : st7_n_r;
      st8_div_r  <= st7_dv_r;
    end
  end

  // fraction divider
  logic           fd_vld [0:FDN];
  logic [FDW-1:0] fd_rem [0:FDN];
  logic [FDW-1:0] fd_div [0:FDN];
  logic [FDQ-1:0] fd_quo [0:FDN];
  logic [FDP-1:0] fd_pay [0:FDN];

  assign fd_vld[0] = st8_v_r;
  assign fd_rem[0] = st8_rem_r;
  assign fd_div[0] = st8_div_r;
  assign fd_quo[0] = FDQ'(st8_q0_r);
  assign fd_pay[0] = {st8_neg_r, st8_dirf_r, st8_rdir_r};

  for (genvar i = 0; i < FDN; i++) begin : g_fd
    awsh_div_cell #(.W(FDW), .QW(FDQ), .PW(FDP)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (fd_vld[i]),
      .in_rem  (fd_rem[i]),
      .in_div  (fd_div[i]),
      .in_quo  (fd_quo[i]),
      .in_bit  (1'b0),
      .in_pay  (fd_pay[i]),
      .out_vld (fd_vld[i+1]),
      .out_rem (fd_rem[i+1]),
      .out_div (fd_div[i+1]),
      .out_quo (fd_quo[i+1]),
      .out_pay (fd_pay[i+1])
    );
  end

  // scale, saturate and restore sign
  logic          fin_neg;
  logic [RW-1:0] fin_r;
  logic [S:0]    m, m_cap, m_sat;
  logic [S-1:0]  res;

  assign fin_neg = fd_pay[FDN][FDP-1];
  assign fin_r   = fd_pay[FDN][FDP-2] ? fd_pay[FDN][RW-1:0] : {1'b0, fd_quo[FDN]};
  assign m       = fin_r[32 -: S+1];
  assign m_cap   = fin_neg ? NEG_CAP : POS_CAP;
  assign m_sat   = (m > m_cap) ? m_cap : m;
  assign res     = fin_neg ? (~m_sat[S-1:0] + 1'b1) : m_sat[S-1:0];

  // output register with skid entry
  logic          take;
  logic [S-1:0]  out_d_r, skid_d_r;
  assign take = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end
    end else if (fd_vld[FDN]) begin
      if (!out_v_r || take) begin
        out_d_r <= res;
        out_v_r <= 1'b1;
      end else begin
        skid_d_r <= res;
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid      = out_v_r;
  assign out_sample_out = out_d_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds data while output register is empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall))
    else $error("skid entry filled without a stalled result");
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(skid_v_r) |-> $past(out_v_r && !out_stall))
    else $error("skid entry drained without an output transfer");
`endif

endmodule
`default_nettype wire

[rtl/core/awsh_div_cell.sv]
// awsh_div_cell: one restoring division step, one quotient bit per cell
// no package dependencies; chained by audio_waveshaper_core
`default_nettype none
module awsh_div_cell #(
  parameter int W  = 17,
  parameter int QW = 34,
  parameter int PW = 41
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [W-1:0]  in_rem,
  input  logic [W-1:0]  in_div,
  input  logic [QW-1:0] in_quo,
  input  logic          in_bit,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [W-1:0]  out_rem,
  output logic [W-1:0]  out_div,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  logic          vld_r;
  logic [W-1:0]  rem_r, div_r;
  logic [QW-1:0] quo_r;
  logic [PW-1:0] pay_r;
  logic [W:0]    trial, diff;
  logic          take;
  logic [W-1:0]  rem_nxt;

  assign trial   = {in_rem, in_bit};
  assign diff    = trial - {1'b0, in_div};
  assign take    = trial >= {1'b0, in_div};
  assign rem_nxt = take ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      div_r <= in_div;
      quo_r <= {in_quo[QW-2:0], take};
      pay_r <= in_pay;
    end
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_div = div_r;
  assign out_quo = quo_r;
  assign out_pay = pay_r;

endmodule
`default_nettype wire

[rtl/core/awsh_cordic_cell.sv]
// awsh_cordic_cell: one CORDIC micro-rotation, hyperbolic rotation or circular vectoring
// depends on awsh_pkg for shift sequence and angle constants
`default_nettype none
module awsh_cordic_cell #(
  parameter int STAGE = 0,
  parameter int XW    = 45,
  parameter int ZW    = 33,
  parameter int PW    = 41
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 hyp,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_vld,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic signed [ZW-1:0] out_z,
  output logic [PW-1:0]        out_pay
);

  localparam int CS = STAGE;
  localparam int HS = awsh_pkg::hyp_shift(STAGE);
  localparam logic signed [ZW-1:0] CA = ZW'(awsh_pkg::circ_angle(CS));
  localparam logic signed [ZW-1:0] HA = ZW'(awsh_pkg::hyp_angle(HS));

  logic                 vld_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [PW-1:0]        pay_r;
  logic signed [XW-1:0] xc, yc, xh, yh;
  logic                 up;

  assign xc = in_x >>> CS;
  assign yc = in_y >>> CS;
  assign xh = in_x >>> HS;
  assign yh = in_y >>> HS;
  assign up = hyp ? !in_z[ZW-1] : !in_y[XW-1];

  always_comb begin
    if (hyp) begin
      x_nxt = up ? in_x + yh : in_x - yh;
      y_nxt = up ? in_y + xh : in_y - xh;
      z_nxt = up ? in_z - HA : in_z + HA;
    end else begin
      x_nxt = up ? in_x + yc : in_x - yc;
      y_nxt = up ? in_y - xc : in_y + xc;
      z_nxt = up ? in_z + CA : in_z - CA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      pay_r <= in_pay;
    end
  end

  assign out_vld = vld_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;
  assign out_pay = pay_r;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// testbench: self-checking bench for audio_waveshaper_core, directed table then random samples
// predicts each shaped sample with a local fixed-point model; depends on awsh_pkg and the core
module testbench;

  localparam int SB = 24;
  localparam int STAGES = 20;
  localparam int LAT = 94;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] out_sample_out;
  logic cfg_we = 1'b0;
  logic [awsh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [24:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  audio_waveshaper_core #(.SAMPLE_BITS(SB), .CORDIC_STAGES(STAGES)) u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_in(in_sample_in), .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  awsh_pkg::shape_mode_t cur_mode;
  logic [15:0] cur_drive;
  logic [24:0] cur_gain;
  logic [SB-1:0] shaped_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet_rx = 1'b0;
  bit hold_rx = 1'b0;
  int hold_len = 0;

  task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                 input logic [SB-1:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    errors++;
  endtask

  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned div_q31(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q, r;
    if (d == 0) return 64'd1 << 32;
    q = n / d;
    if (q >= 2) return 64'd1 << 32;
    r = n % d;
    for (int i = 0; i < 31; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint hyp_tab(input int i);
    longint t[32] = '{0, 589812981, 274247418, 134923406, 67196451, 33565361, 16778582,
      8388779, 4194325, 2097155, 1048576, 524288, 262144, 131072, 65536, 32768, 16384,
      8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint circ_tab(input int i);
    longint t[32] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint unsigned tanh_mag(input longint unsigned a,
                                               input longint unsigned d);
    longint unsigned v, k, rem, tail;
    longint x, y, z, nx;
    int sh;
    bit rep;
    v = (a << 16) / (65536 - d);
    if (v >= (64'd16 << 30)) return 64'd1 << 31;
    k = v / 744261118;
    rem = v - k * 744261118;
    tail = (2 * k >= 64) ? 0 : ((64'd1 << 28) >> (2 * k));
    x = (64'd1 << 28) + tail;
    y = (64'd1 << 28) - tail;
    z = rem;
    sh = 1;
    rep = 1'b0;
    for (int n = 0; n < STAGES; n++) begin
      if (z >= 0) begin
        nx = x + asr(y, sh & 31);
        y = y + asr(x, sh & 31);
        z = z - hyp_tab(sh & 31);
      end else begin
        nx = x - asr(y, sh & 31);
        y = y - asr(x, sh & 31);
        z = z + hyp_tab(sh & 31);
      end
      x = nx;
      if ((sh == 4 || sh == 13) && !rep) rep = 1'b1;
      else begin
        rep = 1'b0;
        sh++;
      end
    end
    if (y <= 0) return 0;
    if (x <= 0) return 64'd1 << 32;
    return div_q31(y, x);
  endfunction

  function automatic longint unsigned atan_mag(input longint unsigned a,
                                               input longint unsigned d);
    longint x, y, z, nx;
    x = (65536 - d) << 15;
    y = (a * 205887) >> 16;
    z = 0;
    for (int n = 0; n < STAGES; n++) begin
      if (y >= 0) begin
        nx = x + asr(y, n);
        y = y - asr(x, n);
        z = z + circ_tab(n);
      end else begin
        nx = x - asr(y, n);
        y = y + asr(x, n);
        z = z - circ_tab(n);
      end
      x = nx;
    end
    if (z <= 0) return 0;
    return (longint'(z) * 64'd2734261102) >> 31;
  endfunction

  function automatic logic [SB-1:0] shape_sample(input logic [SB-1:0] s);
    bit neg;
    longint unsigned mag, a, r, m, cap, d;
    neg = s[SB-1];
    mag = neg ? ((64'd1 << SB) - s) : s;
    a = (mag * cur_gain) >> (SB - 15);
    d = cur_drive;
    if (a == 0) r = 0;
    else begin
      case (cur_mode)
        awsh_pkg::MODE_TANH:     r = tanh_mag(a, d);
        awsh_pkg::MODE_ATAN:     r = atan_mag(a, d);
        awsh_pkg::MODE_RATIONAL: r = div_q31(a, (64'd1 << 30) + ((a * d) >> 16));
        default: r = (a > 32212254) ? div_q31(107374182, (65536 - d) << 14) : a << 1;
      endcase
    end
    m = r >> (32 - SB);
    cap = neg ? (64'd1 << (SB - 1)) : ((64'd1 << (SB - 1)) - 1);
    if (m > cap) m = cap;
    return neg ? SB'((64'd1 << SB) - m) : SB'(m);
  endfunction

  // receiver side and checker
  always @(posedge clk) begin
    logic [SB-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (shaped_q.size() == 0) report_mismatch("unexpected transfer", out_sample_out, '0);
      else begin
        want = shaped_q.pop_front();
        if (out_sample_out !== want) report_mismatch("sample_out", out_sample_out, want);
      end
    end
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      out_stall <= 1'b1;
    end else if (hold_rx) begin
      hold_len <= 400;
      out_stall <= 1'b1;
    end else out_stall <= quiet_rx ? 1'b0 : ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input awsh_pkg::cfg_idx_t idx, input logic [24:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      awsh_pkg::CFG_SHAPE_MODE:   cur_mode = awsh_pkg::shape_mode_t'(val[1:0]);
      awsh_pkg::CFG_DRIVE_AMOUNT: cur_drive = val[15:0];
      default:                    cur_gain = val;
    endcase
  endtask

  task automatic drain();
    while (shaped_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  // one transfer; returns at the accepting edge with valid still high
  task automatic send_sample(input logic [SB-1:0] s, input bit noisy);
    if (noisy && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 11) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    shaped_q = {shaped_q, shape_sample(s)};
    do @(posedge clk); while (in_stall);
  endtask

  typedef struct {
    logic [1:0] mode;
    logic [15:0] drive;
    logic [24:0] gain;
    logic [SB-1:0] smp;
    bit typed;
    logic [SB-1:0] want;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{awsh_pkg::MODE_ATAN, 16'd16384, 25'd65536, 24'd0, 1, 24'd0},
    '{awsh_pkg::MODE_TANH, 16'd0, 25'd65536, 24'd0, 1, 24'd0},
    '{awsh_pkg::MODE_TANH, 16'd0, 25'd65536, 24'h7FFFFF, 0, 24'd0},
    '{awsh_pkg::MODE_TANH, 16'd0, 25'd65536, 24'h800000, 0, 24'd0},
    '{awsh_pkg::MODE_TANH, 16'd64881, 25'd20724305, 24'h7FFFFF, 0, 24'd0},
    '{awsh_pkg::MODE_TANH, 16'hFFFF, 25'h1FFFFFF, 24'h800000, 0, 24'd0},
    '{awsh_pkg::MODE_ATAN, 16'd0, 25'd65536, 24'h000001, 0, 24'd0},
    '{awsh_pkg::MODE_ATAN, 16'd64881, 25'd20724305, 24'h800000, 0, 24'd0},
    '{awsh_pkg::MODE_ATAN, 16'hFFFF, 25'h1FFFFFF, 24'h7FFFFF, 0, 24'd0},
    '{awsh_pkg::MODE_RATIONAL, 16'd0, 25'd65536, 24'h7FFFFF, 0, 24'd0},
    '{awsh_pkg::MODE_RATIONAL, 16'd0, 25'd65536, 24'h800000, 0, 24'd0},
    '{awsh_pkg::MODE_RATIONAL, 16'hFFFF, 25'h1FFFFFF, 24'hFFFFFF, 0, 24'd0},
    '{awsh_pkg::MODE_THRESH, 16'd0, 25'd65536, 24'h03D70A, 0, 24'd0},
    '{awsh_pkg::MODE_THRESH, 16'd0, 25'd65536, 24'h03D70B, 0, 24'd0},
    '{awsh_pkg::MODE_THRESH, 16'd0, 25'd65536, 24'hFC28F5, 0, 24'd0},
    '{awsh_pkg::MODE_THRESH, 16'hFFFF, 25'd65536, 24'h7FFFFF, 1, 24'h7FFFFF},
    '{awsh_pkg::MODE_THRESH, 16'hFFFF, 25'd65536, 24'h800000, 1, 24'h800000},
    '{awsh_pkg::MODE_THRESH, 16'd0, 25'd0, 24'h7FFFFF, 1, 24'd0},
    '{awsh_pkg::MODE_RATIONAL, 16'd0, 25'd0, 24'h800000, 1, 24'd0},
    '{awsh_pkg::MODE_TANH, 16'd0, 25'd1, 24'h000001, 1, 24'd0}
  };

  initial begin
    logic [SB-1:0] s;
    int pick;
    cur_mode = awsh_pkg::MODE_ATAN;
    cur_drive = 16'd16384;
    cur_gain = 25'd65536;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      in_valid <= 1'b0;
      drain();
      write_reg(awsh_pkg::CFG_SHAPE_MODE, 25'(dir_rows[i].mode));
      write_reg(awsh_pkg::CFG_DRIVE_AMOUNT, 25'(dir_rows[i].drive));
      write_reg(awsh_pkg::CFG_INPUT_GAIN, dir_rows[i].gain);
      cfg_we <= 1'b0;
      send_sample(dir_rows[i].smp, 1'b0);
      if (dir_rows[i].typed && shaped_q[$] !== dir_rows[i].want)
        report_mismatch("predictor row", shaped_q[$], dir_rows[i].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      in_valid <= 1'b0;
      drain();
      write_reg(awsh_pkg::CFG_SHAPE_MODE, 25'(ph % 4));
      pick = $urandom_range(3);
      write_reg(awsh_pkg::CFG_DRIVE_AMOUNT, pick == 0 ? 25'd0 : pick == 1 ? 25'd64881 :
                pick == 2 ? 25'hFFFF : 25'($urandom_range(64881)));
      pick = $urandom_range(3);
      write_reg(awsh_pkg::CFG_INPUT_GAIN, pick == 0 ? 25'd65536 : pick == 1 ? 25'd20724305 :
                pick == 2 ? 25'($urandom) : 25'($urandom_range(20724305, 65536)));
      cfg_we <= 1'b0;
      quiet_rx = (ph == 5);
      if (ph == 3) hold_rx = 1'b1;
      for (int k = 0; k < 75; k++) begin
        case ($urandom_range(3))
          0: s = SB'($urandom);
          1: s = SB'($signed($urandom_range(1000)) - 500);
          2: s = SB'($signed($urandom_range(600000)) - 300000);
          default: s = $urandom_range(1) ? 24'h7FFFFF - SB'($urandom_range(255)) :
                                           24'h800000 + SB'($urandom_range(255));
        endcase
        send_sample(s, ph != 5);
        if (hold_rx && k == 2) hold_rx = 1'b0;
      end
    end
    in_valid <= 1'b0;
    drain();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[audio_waveshaper_core.f]
rtl/core/awsh_pkg.sv
rtl/core/awsh_div_cell.sv
rtl/core/awsh_cordic_cell.sv
rtl/core/audio_waveshaper_core.sv
tb/sv/testbench.sv
